@@ rtl/pidc_pkg.sv @@
// ----------------------------------------------------------------------------
// PID regulator with output clamp: shared definitions
// Widths, register indexes, reset values and sequencer codes.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int DATA_W  = 16;
  localparam int ADDR_W  = 3;
  localparam int INT_W   = 40;
  localparam int DIFF_W  = 17;
  localparam int DER_W   = 34;
  localparam int MUL_A_W = 17;
  localparam int MUL_B_W = 21;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 60;
  localparam int OUT_FRAC = 28;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_KP        = 3'd0;
  localparam reg_idx_t REG_KI        = 3'd1;
  localparam reg_idx_t REG_KD        = 3'd2;
  localparam reg_idx_t REG_DT_STEP   = 3'd3;
  localparam reg_idx_t REG_RATE_INV  = 3'd4;
  localparam reg_idx_t REG_STEER_MIN = 3'd5;
  localparam reg_idx_t REG_STEER_MAX = 3'd6;

  localparam logic [DATA_W-1:0] RST_KP        = 16'd2048;
  localparam logic [DATA_W-1:0] RST_KI        = 16'd41;
  localparam logic [DATA_W-1:0] RST_KD        = 16'd0;
  localparam logic [DATA_W-1:0] RST_DT_STEP   = 16'd13107;
  localparam logic [DATA_W-1:0] RST_RATE_INV  = 16'd1280;
  localparam logic [DATA_W-1:0] RST_STEER_MIN = 16'hE6DE;
  localparam logic [DATA_W-1:0] RST_STEER_MAX = 16'd6434;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [2:0] STEP_E_DT    = 3'd0;
  localparam logic [2:0] STEP_DIFF    = 3'd1;
  localparam logic [2:0] STEP_KP      = 3'd2;
  localparam logic [2:0] STEP_KI_LO   = 3'd3;
  localparam logic [2:0] STEP_KI_HI   = 3'd4;
  localparam logic [2:0] STEP_KD_LO   = 3'd5;
  localparam logic [2:0] STEP_KD_HI   = 3'd6;
  localparam logic [2:0] STEP_LAST    = 3'd7;

endpackage

@@ rtl/pid_with_output_clamp_unit.sv @@
// ----------------------------------------------------------------------------
// PID regulator with output clamp
// Fixed-point PID over one shared 17x21 multiplier driven by a step counter.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one Q4.12 error word per item on in_valid/in_ready.
// The result channel gives the clamped Q4.12 steering word and a clamp flag
// on out_valid/out_ready. Gains, period, reciprocal period and limits are set
// through cfg_we/cfg_addr/cfg_wdata; the user must write them only while no
// item is in flight, since the block itself does not enforce this.
// Each item takes eight sequencer steps on the shared multiplier (seven
// products, one product registered per step and accumulated in the next)
// plus one step for the limit compare and rounding. in_ready is high again
// the cycle after the result is loaded, so no new item is taken before then.
// The output register holds a finished word while the receiver stalls, and a
// new item may be accepted meanwhile; the final step waits for the register.
// Synchronous reset clears the integral and previous error, loads the
// default gains, period, reciprocal period and limits, and drops out_valid.
module pid_with_output_clamp_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pidc_pkg::word_t         in_error_sample,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pidc_pkg::word_t         out_steering,
  output logic                    out_clamped,
  input  logic                    cfg_we,
  input  pidc_pkg::reg_idx_t      cfg_addr,
  input  logic [15:0]             cfg_wdata
);
  import pidc_pkg::*;

  logic [1:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;

  logic signed [DATA_W-1:0] kp_r, ki_r, kd_r, steer_min_r, steer_max_r;
  logic [DATA_W-1:0] dt_step_r, rate_inv_r;

  logic signed [DATA_W-1:0] err_r, prev_err_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [INT_W-1:0]  integ_r, integ_nxt;
  logic signed [DER_W-1:0]  deriv_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [INT_W:0]     integ_sum;
  logic signed [ACC_W-1:0]   lim_hi, lim_lo, rounded;

  logic out_valid_r;
  word_t out_steering_r;
  logic out_clamped_r;
  logic accept, finish;

  assign accept   = in_valid && in_ready;
  assign finish   = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= RST_KP;
      ki_r        <= RST_KI;
      kd_r        <= RST_KD;
      dt_step_r   <= RST_DT_STEP;
      rate_inv_r  <= RST_RATE_INV;
      steer_min_r <= RST_STEER_MIN;
      steer_max_r <= RST_STEER_MAX;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KP:        kp_r        <= cfg_wdata;
        REG_KI:        ki_r        <= cfg_wdata;
        REG_KD:        kd_r        <= cfg_wdata;
        REG_DT_STEP:   dt_step_r   <= cfg_wdata;
        REG_RATE_INV:  rate_inv_r  <= cfg_wdata;
        REG_STEER_MIN: steer_min_r <= cfg_wdata;
        REG_STEER_MAX: steer_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Operand select for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      STEP_E_DT: begin
        mul_a = {err_r[DATA_W-1], err_r};
        mul_b = {{(MUL_B_W-DATA_W){1'b0}}, dt_step_r};
      end
      STEP_DIFF: begin
        mul_a = diff_r;
        mul_b = {{(MUL_B_W-DATA_W){1'b0}}, rate_inv_r};
      end
      STEP_KP: begin
        mul_a = {kp_r[DATA_W-1], kp_r};
        mul_b = {{(MUL_B_W-DATA_W){err_r[DATA_W-1]}}, err_r};
      end
      STEP_KI_LO: begin
        mul_a = {ki_r[DATA_W-1], ki_r};
        mul_b = {1'b0, integ_r[19:0]};
      end
      STEP_KI_HI: begin
        mul_a = {ki_r[DATA_W-1], ki_r};
        mul_b = {integ_r[INT_W-1], integ_r[INT_W-1:20]};
      end
      STEP_KD_LO: begin
        mul_a = {kd_r[DATA_W-1], kd_r};
        mul_b = {4'b0, deriv_r[16:0]};
      end
      STEP_KD_HI: begin
        mul_a = {kd_r[DATA_W-1], kd_r};
        mul_b = {{(MUL_B_W-17){deriv_r[DER_W-1]}}, deriv_r[DER_W-1:17]};
      end
      default: ;
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // Integral update with saturation to the signed 40-bit range.
  always_comb begin
    integ_sum = {integ_r[INT_W-1], integ_r} + {{(INT_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    integ_nxt = integ_sum[INT_W-1:0];
    if (integ_sum[INT_W] != integ_sum[INT_W-1]) begin
      integ_nxt = integ_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
    end
  end

  // Accumulation of the three terms in Q.40.
  always_comb begin
    acc_nxt = acc_r;
    case (step_r)
      STEP_KI_LO: acc_nxt = prod_ext <<< 16;
      STEP_KI_HI: acc_nxt = acc_r + prod_ext;
      STEP_KD_LO: acc_nxt = acc_r + (prod_ext <<< 20);
      STEP_KD_HI: acc_nxt = acc_r + (prod_ext <<< 8);
      STEP_LAST:  acc_nxt = acc_r + (prod_ext <<< 25);
      default: ;
    endcase
  end

  assign lim_hi  = {{(ACC_W-DATA_W-OUT_FRAC){steer_max_r[DATA_W-1]}}, steer_max_r,
                    {OUT_FRAC{1'b0}}};
  assign lim_lo  = {{(ACC_W-DATA_W-OUT_FRAC){steer_min_r[DATA_W-1]}}, steer_min_r,
                    {OUT_FRAC{1'b0}}};
  assign rounded = acc_r + {{(ACC_W-OUT_FRAC){1'b0}}, 1'b1, {(OUT_FRAC-1){1'b0}}};

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_LAST) begin
          state_nxt = ST_DONE;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_DONE: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      prev_err_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (accept) begin
        prev_err_r <= in_error_sample;
      end
      if (state_r == ST_RUN && step_r == STEP_DIFF) begin
        integ_r <= integ_nxt;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r  <= in_error_sample;
      diff_r <= {in_error_sample[DATA_W-1], in_error_sample}
              - {prev_err_r[DATA_W-1], prev_err_r};
    end
    if (state_r == ST_RUN) begin
      prod_r <= mul_p;
      acc_r  <= acc_nxt;
      if (step_r == STEP_KP) begin
        deriv_r <= prod_r[DER_W-1:0];
      end
    end
    if (finish) begin
      if (acc_r > lim_hi) begin
        out_steering_r <= steer_max_r;
        out_clamped_r  <= 1'b1;
      end else if (acc_r <= lim_lo) begin
        out_steering_r <= steer_min_r;
        out_clamped_r  <= 1'b1;
      end else begin
        out_steering_r <= rounded[OUT_FRAC+DATA_W-1:OUT_FRAC];
        out_clamped_r  <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_steering = out_steering_r;
  assign out_clamped  = out_clamped_r;

`ifndef ASSERT_OFF
  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN) && (step_r == STEP_E_DT))
    else $error("accepted word did not start the sequencer");

  a_step_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> (step_r == '0))
    else $error("step counter moved outside the run state");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result appeared without a finished computation");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished result was not loaded");
`endif

endmodule
